FILE: rtl/core/dc_pkg.sv
// ----------------------------------------------------------------------------
// dc_pkg
// Shared types, constants and month tables for the calendar date core.
// ----------------------------------------------------------------------------
package dc_pkg;

    // command codes
    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_CHECK   = 1'b1;

    // day count range, 1 is the first day of 1900
    localparam logic signed [17:0] DAY_COUNT_MIN = 18'sd1;
    localparam logic signed [17:0] DAY_COUNT_MAX = 18'sd73049;
    localparam logic [16:0]        DAY_INDEX_MAX = 17'd73048;

    localparam logic [16:0] YEAR_DAYS  = 17'd365;
    localparam logic [16:0] QUAD_DAYS  = 17'd1461;

    // rest / 1461 == (rest * QUAD_RECIP) >> RECIP_SHIFT for rest below 94519
    localparam logic [16:0] QUAD_RECIP  = 17'd91868;
    localparam int          RECIP_SHIFT = 27;

    localparam logic [15:0] YEAR_IN_MIN  = 16'd1900;
    localparam logic [15:0] YEAR_IN_MAX  = 16'd2099;
    localparam logic [11:0] YEAR_BASE    = 12'd1900;
    localparam logic [11:0] YEAR_QUAD0   = 12'd1901;
    localparam logic [11:0] YEAR_DEFAULT = 12'd2000;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [4:0] DAY_FIRST   = 5'd1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        leap;
    } t_carry;

    // length of a month, leap only matters for february
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // zero-based day of year on which a month starts
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        logic [8:0] adj;
        adj = (leap && m > 4'd2) ? 9'd1 : 9'd0;
        case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + adj;
    endfunction

endpackage

FILE: rtl/core/dc_front.sv
// ----------------------------------------------------------------------------
// dc_front
// First stage: clamps the day count and splits off the first year, and
// checks and corrects a year, month and day for the check command.
// ----------------------------------------------------------------------------
module dc_front (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_command,
    input  logic signed [17:0] i_day_count,
    input  logic [15:0]        i_year_in,
    input  logic [7:0]         i_month_in,
    input  logic [7:0]         i_day_in,
    output dc_pkg::t_carry     o_carry,
    output logic               o_first,
    output logic [16:0]        o_rest,
    output logic [8:0]         o_doy
);
    import dc_pkg::*;

    t_carry      r_carry, n_carry;
    logic        r_first, n_first;
    logic [16:0] r_rest, n_rest;
    logic [8:0]  r_doy, n_doy;

    logic [16:0] w_idx;
    logic [4:0]  w_len;

    always_comb begin
        if (i_day_count < DAY_COUNT_MIN) begin
            w_idx = 17'd0;
        end else if (i_day_count > DAY_COUNT_MAX) begin
            w_idx = DAY_INDEX_MAX;
        end else begin
            w_idx = i_day_count[16:0] - 17'd1;
        end
        n_first = (w_idx < YEAR_DAYS);
        n_rest  = n_first ? 17'd0 : (w_idx - YEAR_DAYS);
        n_doy   = w_idx[8:0];

        n_carry.cmd = i_command;
        if (i_year_in >= YEAR_IN_MIN && i_year_in <= YEAR_IN_MAX) begin
            n_carry.year = i_year_in[11:0];
        end else begin
            n_carry.year = YEAR_DEFAULT;
        end
        // in 1900..2099 only 1900 breaks the every-fourth-year rule
        n_carry.leap = (n_carry.year[1:0] == 2'b00) && (n_carry.year != YEAR_BASE);
        if (i_month_in >= 8'(MONTH_FIRST) && i_month_in <= 8'(MONTH_LAST)) begin
            n_carry.month = i_month_in[3:0];
        end else begin
            n_carry.month = MONTH_FIRST;
        end
        w_len = month_len(n_carry.month, n_carry.leap);
        if (i_day_in >= 8'(DAY_FIRST) && i_day_in <= {3'd0, w_len}) begin
            n_carry.day = i_day_in[4:0];
        end else begin
            n_carry.day = DAY_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_carry <= n_carry;
            r_first <= n_first;
            r_rest  <= n_rest;
            r_doy   <= n_doy;
        end
    end

    assign o_carry = r_carry;
    assign o_first = r_first;
    assign o_rest  = r_rest;
    assign o_doy   = r_doy;

endmodule

FILE: rtl/core/dc_year.sv
// ----------------------------------------------------------------------------
// dc_year
// Three stages: four-year block by reciprocal multiply, remainder within
// the block, then year and zero-based day of year.
// ----------------------------------------------------------------------------
module dc_year (
    input  logic           i_clk,
    input  logic [2:0]     i_load,
    input  dc_pkg::t_carry i_carry,
    input  logic           i_first,
    input  logic [16:0]    i_rest,
    input  logic [8:0]     i_doy,
    output dc_pkg::t_carry o_carry,
    output logic [11:0]    o_year,
    output logic [8:0]     o_doy,
    output logic           o_leap
);
    import dc_pkg::*;

    // block index stage
    t_carry      r_s2_carry;
    logic        r_s2_first;
    logic [16:0] r_s2_rest;
    logic [8:0]  r_s2_doy;
    logic [5:0]  r_s2_q, n_s2_q;

    // remainder stage
    t_carry      r_s3_carry;
    logic        r_s3_first;
    logic [8:0]  r_s3_doy;
    logic [5:0]  r_s3_q;
    logic [10:0] r_s3_r, n_s3_r;

    // year stage
    t_carry      r_s4_carry;
    logic [11:0] r_s4_year, n_s4_year;
    logic [8:0]  r_s4_doy, n_s4_doy;
    logic        r_s4_leap, n_s4_leap;

    logic [33:0] w_prod;
    logic [16:0] w_qmul;
    logic [16:0] w_rem;
    logic [1:0]  w_yy;
    logic [10:0] w_yoff;
    logic [10:0] w_dif;

    always_comb begin
        w_prod = {17'd0, i_rest} * {17'd0, QUAD_RECIP};
        n_s2_q = w_prod[RECIP_SHIFT +: 6];
    end

    always_comb begin
        w_qmul = {11'd0, r_s2_q} * QUAD_DAYS;
        w_rem  = r_s2_rest - w_qmul;
        n_s3_r = w_rem[10:0];
    end

    always_comb begin
        if (r_s3_r >= 11'd1095) begin
            w_yy   = 2'd3;
            w_yoff = 11'd1095;
        end else if (r_s3_r >= 11'd730) begin
            w_yy   = 2'd2;
            w_yoff = 11'd730;
        end else if (r_s3_r >= 11'd365) begin
            w_yy   = 2'd1;
            w_yoff = 11'd365;
        end else begin
            w_yy   = 2'd0;
            w_yoff = 11'd0;
        end
        w_dif = r_s3_r - w_yoff;
        if (r_s3_first) begin
            n_s4_year = YEAR_BASE;
            n_s4_doy  = r_s3_doy;
            n_s4_leap = 1'b0;
        end else begin
            n_s4_year = YEAR_QUAD0 + {4'd0, r_s3_q, 2'b00} + {10'd0, w_yy};
            n_s4_doy  = w_dif[8:0];
            // the fourth year of each block is the leap year
            n_s4_leap = (w_yy == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s2_carry <= i_carry;
            r_s2_first <= i_first;
            r_s2_rest  <= i_rest;
            r_s2_doy   <= i_doy;
            r_s2_q     <= n_s2_q;
        end
        if (i_load[1]) begin
            r_s3_carry <= r_s2_carry;
            r_s3_first <= r_s2_first;
            r_s3_doy   <= r_s2_doy;
            r_s3_q     <= r_s2_q;
            r_s3_r     <= n_s3_r;
        end
        if (i_load[2]) begin
            r_s4_carry <= r_s3_carry;
            r_s4_year  <= n_s4_year;
            r_s4_doy   <= n_s4_doy;
            r_s4_leap  <= n_s4_leap;
        end
    end

    assign o_carry = r_s4_carry;
    assign o_year  = r_s4_year;
    assign o_doy   = r_s4_doy;
    assign o_leap  = r_s4_leap;

endmodule

FILE: rtl/core/dc_month.sv
// ----------------------------------------------------------------------------
// dc_month
// Last stage: month and day from the day of year, command select, and
// the output register.
// ----------------------------------------------------------------------------
module dc_month (
    input  logic           i_clk,
    input  logic           i_load,
    input  dc_pkg::t_carry i_carry,
    input  logic [11:0]    i_year,
    input  logic [8:0]     i_doy,
    input  logic           i_leap,
    output logic [11:0]    o_year,
    output logic [3:0]     o_month,
    output logic [4:0]     o_day,
    output logic           o_leap
);
    import dc_pkg::*;

    logic [11:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic        r_leap, n_leap;

    logic [3:0] w_month;
    logic [8:0] w_day;

    always_comb begin
        w_month = MONTH_FIRST;
        // starts rise with the month, so the last hit is the month
        for (int m = 2; m <= 12; m++) begin
            if (i_doy >= month_start(4'(m), i_leap)) begin
                w_month = 4'(m);
            end
        end
        w_day = i_doy - month_start(w_month, i_leap) + 9'd1;

        if (i_carry.cmd == CMD_CHECK) begin
            n_year  = i_carry.year;
            n_month = i_carry.month;
            n_day   = i_carry.day;
            n_leap  = i_carry.leap;
        end else begin
            n_year  = i_year;
            n_month = w_month;
            n_day   = w_day[4:0];
            n_leap  = i_leap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_leap  <= n_leap;
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;
    assign o_leap  = r_leap;

endmodule

FILE: rtl/core/day_count_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_core
// Turns a day count into a date for 1900..2099, or checks and corrects a
// given date, with the leap-year flag of the resulting year.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  input    in         i_valid / o_ready   i_command i_day_count i_year_in
//                                          i_month_in i_day_in
//  output   out        o_valid / i_ready   o_year_out o_month_out o_day_out
//                                          o_leap_flag
//
//  five register stages, one transfer per cycle sustained while i_ready holds
//  the four-year block division is a 17x17 reciprocal multiply in stage two
//  each stage loads when it is empty or the stage after it moves on, so a
//  stall on the output backs up stage by stage without dropping or repeating
//  reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module day_count_to_calendar_date_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic signed [17:0] i_day_count,
    input  logic [15:0]        i_year_in,
    input  logic [7:0]         i_month_in,
    input  logic [7:0]         i_day_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [11:0]        o_year_out,
    output logic [3:0]         o_month_out,
    output logic [4:0]         o_day_out,
    output logic               o_leap_flag
);
    import dc_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0] r_valid, n_valid;
    logic [STAGES-1:0] w_adv;

    t_carry      w_s1_carry;
    logic        w_s1_first;
    logic [16:0] w_s1_rest;
    logic [8:0]  w_s1_doy;
    t_carry      w_s4_carry;
    logic [11:0] w_s4_year;
    logic [8:0]  w_s4_doy;
    logic        w_s4_leap;

    always_comb begin
        w_adv[STAGES-1] = !r_valid[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
        n_valid[0] = w_adv[0] ? i_valid : r_valid[0];
        for (int k = 1; k < STAGES; k++) begin
            n_valid[k] = w_adv[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_valid[STAGES-1];

    dc_front u_front (
        .i_clk       (i_clk),
        .i_load      (w_adv[0]),
        .i_command   (i_command),
        .i_day_count (i_day_count),
        .i_year_in   (i_year_in),
        .i_month_in  (i_month_in),
        .i_day_in    (i_day_in),
        .o_carry     (w_s1_carry),
        .o_first     (w_s1_first),
        .o_rest      (w_s1_rest),
        .o_doy       (w_s1_doy)
    );

    dc_year u_year (
        .i_clk   (i_clk),
        .i_load  (w_adv[3:1]),
        .i_carry (w_s1_carry),
        .i_first (w_s1_first),
        .i_rest  (w_s1_rest),
        .i_doy   (w_s1_doy),
        .o_carry (w_s4_carry),
        .o_year  (w_s4_year),
        .o_doy   (w_s4_doy),
        .o_leap  (w_s4_leap)
    );

    dc_month u_month (
        .i_clk   (i_clk),
        .i_load  (w_adv[4]),
        .i_carry (w_s4_carry),
        .i_year  (w_s4_year),
        .i_doy   (w_s4_doy),
        .i_leap  (w_s4_leap),
        .o_year  (o_year_out),
        .o_month (o_month_out),
        .o_day   (o_day_out),
        .o_leap  (o_leap_flag)
    );

    // a blocked input means every stage is holding an item
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_valid == {STAGES{1'b1}}))
        else $error("input blocked while a stage is empty");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_out >= YEAR_BASE && o_year_out <= 12'd2099
                     && o_month_out >= MONTH_FIRST && o_month_out <= MONTH_LAST
                     && o_day_out >= DAY_FIRST
                     && o_day_out <= month_len(o_month_out, o_leap_flag)))
        else $error("result date out of range");

    a_leap_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_leap_flag == ((o_year_out[1:0] == 2'b00)
                                     && (o_year_out != YEAR_BASE))))
        else $error("leap flag does not match result year");

endmodule
